### rtl/rbd_pkg.sv
package rbd_pkg;

  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 31;

  localparam logic signed [31:0] OneQ30 = 32'sh4000_0000;

  typedef logic [2:0][31:0] vec32_t;
  typedef logic [2:0][63:0] vec64_t;

  // divide by 2^30, round half away from zero
  function automatic logic signed [35:0] round_q30(input logic signed [65:0] v);
    logic [65:0] mag;
    logic [65:0] sum;
    logic [35:0] m36;
    mag = v[65] ? 66'(-v) : 66'(v);
    sum = (mag + (66'd1 << 29)) >> 30;
    m36 = sum[35:0];
    round_q30 = v[65] ? -$signed(m36) : $signed(m36);
  endfunction

  function automatic logic signed [31:0] sat_one(input logic signed [35:0] v);
    if (v > 36'sd1073741824) begin
      sat_one = OneQ30;
    end else if (v < -36'sd1073741824) begin
      sat_one = -OneQ30;
    end else begin
      sat_one = v[31:0];
    end
  endfunction

endpackage

### rtl/rotation_basis_from_direction.sv
// Look-at rotation basis: each input word carries a direction and an up hint (signed
// Q16.16) and gives one output word with the right, new up and forward axes (signed
// Q2.30, 1.0 = 2^30). Fully pipelined: one word per cycle sustained while the output is
// not stalled; the pipeline runs through two normalizers (32-step square root and
// 31-step divide each). An output skid register keeps the input flowing while a result
// waits; a stall loses nothing.
module rotation_basis_from_direction (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // dir_x, dir_y, dir_z, up_x, up_y, up_z
  input  logic [191:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // right_x/y/z, new_up_x/y/z, forward_x/y/z
  output logic [287:0] m_axis_tdata_o
);

  logic            pipe_en;
  rbd_pkg::vec32_t dir, up;
  rbd_pkg::vec64_t dir64;

  logic            n1_valid;
  rbd_pkg::vec32_t n1_f, n1_up;
  logic            pr_valid;
  rbd_pkg::vec64_t pr_r;
  rbd_pkg::vec32_t pr_f;
  logic            n2_valid;
  rbd_pkg::vec32_t n2_nu, n2_f;
  logic            cr_valid;
  logic [287:0]    cr_data;

  logic            m_valid_q;
  logic [287:0]    m_data_q;
  logic            sk_valid_q;
  logic [287:0]    sk_data_q;

  assign pipe_en         = ~sk_valid_q;
  assign s_axis_tready_o = pipe_en;

  assign dir = s_axis_tdata_i[95:0];
  assign up  = s_axis_tdata_i[191:96];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir64[i] = 64'($signed(dir[i]));
    end
  end

  rbd_norm u_norm_dir (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s_axis_tvalid_i),
    .vec_i   (dir64),
    .pay_i   (up),
    .valid_o (n1_valid),
    .q_o     (n1_f),
    .pay_o   (n1_up)
  );

  rbd_proj u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (n1_valid),
    .up_i    (n1_up),
    .f_i     (n1_f),
    .valid_o (pr_valid),
    .r_o     (pr_r),
    .f_o     (pr_f)
  );

  rbd_norm u_norm_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (pr_valid),
    .vec_i   (pr_r),
    .pay_i   (pr_f),
    .valid_o (n2_valid),
    .q_o     (n2_nu),
    .pay_o   (n2_f)
  );

  rbd_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (n2_valid),
    .nu_i    (n2_nu),
    .f_i     (n2_f),
    .valid_o (cr_valid),
    .data_o  (cr_data)
  );

  // output register plus skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q  <= 1'b0;
      sk_valid_q <= 1'b0;
    end else if (!m_valid_q || m_axis_tready_i) begin
      if (sk_valid_q) begin
        m_valid_q  <= 1'b1;
        sk_valid_q <= 1'b0;
      end else begin
        m_valid_q <= cr_valid;
      end
    end else if (cr_valid && !sk_valid_q) begin
      sk_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!m_valid_q || m_axis_tready_i) begin
      m_data_q <= sk_valid_q ? sk_data_q : cr_data;
    end else if (!sk_valid_q) begin
      sk_data_q <= cr_data;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_valid_q |-> m_valid_q)
    else $error("skid holds a word while output register is empty");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(cr_valid) && $stable(cr_data))
    else $error("pipeline moved while stalled");

  a_zero_up_zero_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_data_q[191:96] == '0) |-> m_data_q[95:0] == '0)
    else $error("right axis nonzero with zero up axis");

endmodule

### rtl/rbd_norm.sv
module rbd_norm (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  rbd_pkg::vec64_t vec_i,
  input  rbd_pkg::vec32_t pay_i,
  output logic            valid_o,
  output rbd_pkg::vec32_t q_o,
  output rbd_pkg::vec32_t pay_o
);

  localparam int unsigned SqN = rbd_pkg::SqrtSteps;
  localparam int unsigned DvN = rbd_pkg::DivSteps;

  typedef struct packed {
    logic [2:0][30:0]  m;
    logic [2:0]        neg;
    logic              zero;
    rbd_pkg::vec32_t   pay;
  } side_t;

  function automatic logic [2:0] msb8(input logic [7:0] b);
    logic [2:0] pos;
    pos = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) pos = 3'(i);
    end
    msb8 = pos;
  endfunction

  // stage a: magnitudes
  logic             a_valid_q;
  logic [2:0][63:0] a_mag_q, a_mag_d;
  logic [63:0]      a_or_q, a_or_d;
  logic [2:0]       a_neg_q, a_neg_d;
  rbd_pkg::vec32_t  a_pay_q;

  // stage b: per-byte leading one
  logic             b_valid_q;
  logic [2:0][63:0] b_mag_q;
  logic [7:0]       b_nz_q, b_nz_d;
  logic [7:0][2:0]  b_pos_q, b_pos_d;
  logic [2:0]       b_neg_q;
  rbd_pkg::vec32_t  b_pay_q;

  // stage c: leading one position
  logic             c_valid_q;
  logic [2:0][63:0] c_mag_q;
  logic [5:0]       c_p_q, c_p_d;
  logic             c_zero_q, c_zero_d;
  logic [2:0]       c_neg_q;
  rbd_pkg::vec32_t  c_pay_q;

  // stage d: scaled magnitudes
  logic             d_valid_q;
  side_t            d_side_q, d_side_d;

  // stage e: squares
  logic             e_valid_q;
  logic [2:0][61:0] e_sq_q, e_sq_d;
  side_t            e_side_q;

  // stage f: sum of squares
  logic             f_valid_q;
  logic [63:0]      f_sum_q, f_sum_d;
  side_t            f_side_q;

  // square root steps
  logic             sqv_q [SqN];
  logic [63:0]      sqx_q [SqN];
  logic [63:0]      sqx_d [SqN];
  logic [63:0]      sqr_q [SqN];
  logic [63:0]      sqr_d [SqN];
  side_t            sqs_q [SqN];
  logic [63:0]      sq_xin, sq_rin, sq_b;
  logic [64:0]      sq_rb;

  // stage g: numerators
  logic             g_valid_q;
  logic [31:0]      g_n_q;
  logic [2:0][61:0] g_num_q, g_num_d;
  side_t            g_side_q;

  // divide steps
  logic             dvv_q [DvN];
  logic [2:0][31:0] dvr_q [DvN];
  logic [2:0][31:0] dvr_d [DvN];
  logic [2:0][30:0] dvq_q [DvN];
  logic [2:0][30:0] dvq_d [DvN];
  logic [2:0][61:0] dvnum_q [DvN];
  logic [31:0]      dvn_q [DvN];
  side_t            dvs_q [DvN];
  logic [31:0]      dv_rin;
  logic [30:0]      dv_qin;
  logic [32:0]      dv_rem2;

  // stage h: sign and result
  logic             h_valid_q;
  rbd_pkg::vec32_t  h_q_q, h_q_d;
  rbd_pkg::vec32_t  h_pay_q;
  logic [30:0]      h_cap;

  always_comb begin
    a_or_d = '0;
    for (int i = 0; i < 3; i++) begin
      a_neg_d[i] = vec_i[i][63];
      a_mag_d[i] = vec_i[i][63] ? 64'(-vec_i[i]) : vec_i[i];
      a_or_d     = a_or_d | a_mag_d[i];
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      b_nz_d[k]  = |a_or_q[8*k +: 8];
      b_pos_d[k] = msb8(a_or_q[8*k +: 8]);
    end
  end

  always_comb begin
    c_p_d    = '0;
    c_zero_d = ~|b_nz_q;
    for (int k = 0; k < 8; k++) begin
      if (b_nz_q[k]) c_p_d = {3'(k), b_pos_q[k]};
    end
  end

  always_comb begin
    d_side_d.neg  = c_neg_q;
    d_side_d.zero = c_zero_q;
    d_side_d.pay  = c_pay_q;
    for (int i = 0; i < 3; i++) begin
      if (c_p_q > 6'd30) begin
        d_side_d.m[i] = 31'(c_mag_q[i] >> 6'(c_p_q - 6'd30));
      end else begin
        d_side_d.m[i] = 31'(c_mag_q[i] << 6'(6'd30 - c_p_q));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_sq_d[i] = d_side_q.m[i] * d_side_q.m[i];
    end
  end

  assign f_sum_d = 64'(e_sq_q[0]) + 64'(e_sq_q[1]) + 64'(e_sq_q[2]);

  always_comb begin
    sq_xin = '0;
    sq_rin = '0;
    sq_b   = '0;
    sq_rb  = '0;
    for (int k = 0; k < SqN; k++) begin
      if (k == 0) begin
        sq_xin = f_sum_q;
        sq_rin = '0;
      end else begin
        sq_xin = sqx_q[k-1];
        sq_rin = sqr_q[k-1];
      end
      sq_b  = 64'd1 << (2 * (SqN - 1 - k));
      sq_rb = {1'b0, sq_rin} + {1'b0, sq_b};
      if ({1'b0, sq_xin} >= sq_rb) begin
        sqx_d[k] = 64'({1'b0, sq_xin} - sq_rb);
        sqr_d[k] = (sq_rin >> 1) + sq_b;
      end else begin
        sqx_d[k] = sq_xin;
        sqr_d[k] = sq_rin >> 1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g_num_d[i] = 62'({sqs_q[SqN-1].m[i], 30'b0}) + 62'(sqr_q[SqN-1][31:1]);
    end
  end

  always_comb begin
    dv_rin  = '0;
    dv_qin  = '0;
    dv_rem2 = '0;
    for (int k = 0; k < DvN; k++) begin
      for (int i = 0; i < 3; i++) begin
        if (k == 0) begin
          dv_rin  = {1'b0, g_num_q[i][61:31]};
          dv_qin  = '0;
          dv_rem2 = {dv_rin, g_num_q[i][DvN-1-k]};
          if (dv_rem2 >= {1'b0, g_n_q}) begin
            dvr_d[k][i] = 32'(dv_rem2 - {1'b0, g_n_q});
            dv_qin[DvN-1-k] = 1'b1;
          end else begin
            dvr_d[k][i] = dv_rem2[31:0];
          end
        end else begin
          dv_rin  = dvr_q[k-1][i];
          dv_qin  = dvq_q[k-1][i];
          dv_rem2 = {dv_rin, dvnum_q[k-1][i][DvN-1-k]};
          if (dv_rem2 >= {1'b0, dvn_q[k-1]}) begin
            dvr_d[k][i] = 32'(dv_rem2 - {1'b0, dvn_q[k-1]});
            dv_qin[DvN-1-k] = 1'b1;
          end else begin
            dvr_d[k][i] = dv_rem2[31:0];
          end
        end
        dvq_d[k][i] = dv_qin;
      end
    end
  end

  always_comb begin
    h_cap = '0;
    for (int i = 0; i < 3; i++) begin
      h_cap = (dvq_q[DvN-1][i] > 31'h4000_0000) ? 31'h4000_0000 : dvq_q[DvN-1][i];
      if (dvs_q[DvN-1].zero) begin
        h_q_d[i] = '0;
      end else if (dvs_q[DvN-1].neg[i]) begin
        h_q_d[i] = -{1'b0, h_cap};
      end else begin
        h_q_d[i] = {1'b0, h_cap};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
      g_valid_q <= 1'b0;
      h_valid_q <= 1'b0;
      for (int k = 0; k < SqN; k++) sqv_q[k] <= 1'b0;
      for (int k = 0; k < DvN; k++) dvv_q[k] <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      d_valid_q <= c_valid_q;
      e_valid_q <= d_valid_q;
      f_valid_q <= e_valid_q;
      for (int k = 0; k < SqN; k++) sqv_q[k] <= (k == 0) ? f_valid_q : sqv_q[k-1];
      g_valid_q <= sqv_q[SqN-1];
      for (int k = 0; k < DvN; k++) dvv_q[k] <= (k == 0) ? g_valid_q : dvv_q[k-1];
      h_valid_q <= dvv_q[DvN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_mag_q  <= a_mag_d;
      a_or_q   <= a_or_d;
      a_neg_q  <= a_neg_d;
      a_pay_q  <= pay_i;
      b_mag_q  <= a_mag_q;
      b_nz_q   <= b_nz_d;
      b_pos_q  <= b_pos_d;
      b_neg_q  <= a_neg_q;
      b_pay_q  <= a_pay_q;
      c_mag_q  <= b_mag_q;
      c_p_q    <= c_p_d;
      c_zero_q <= c_zero_d;
      c_neg_q  <= b_neg_q;
      c_pay_q  <= b_pay_q;
      d_side_q <= d_side_d;
      e_sq_q   <= e_sq_d;
      e_side_q <= d_side_q;
      f_sum_q  <= f_sum_d;
      f_side_q <= e_side_q;
      for (int k = 0; k < SqN; k++) begin
        sqx_q[k] <= sqx_d[k];
        sqr_q[k] <= sqr_d[k];
        sqs_q[k] <= (k == 0) ? f_side_q : sqs_q[k-1];
      end
      g_n_q    <= sqr_q[SqN-1][31:0];
      g_num_q  <= g_num_d;
      g_side_q <= sqs_q[SqN-1];
      for (int k = 0; k < DvN; k++) begin
        dvr_q[k]   <= dvr_d[k];
        dvq_q[k]   <= dvq_d[k];
        dvnum_q[k] <= (k == 0) ? g_num_q : dvnum_q[k-1];
        dvn_q[k]   <= (k == 0) ? g_n_q : dvn_q[k-1];
        dvs_q[k]   <= (k == 0) ? g_side_q : dvs_q[k-1];
      end
      h_q_q   <= h_q_d;
      h_pay_q <= dvs_q[DvN-1].pay;
    end
  end

  assign valid_o = h_valid_q;
  assign q_o     = h_q_q;
  assign pay_o   = h_pay_q;

endmodule

### rtl/rbd_proj.sv
module rbd_proj (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  rbd_pkg::vec32_t up_i,
  input  rbd_pkg::vec32_t f_i,
  output logic            valid_o,
  output rbd_pkg::vec64_t r_o,
  output rbd_pkg::vec32_t f_o
);

  logic             p1_valid_q, p2_valid_q, p3_valid_q, p4_valid_q;
  logic [2:0][63:0] p1_prod_q, p1_prod_d;
  logic signed [35:0] p2_t_q, p2_t_d;
  logic [2:0][67:0] p3_ft_q, p3_ft_d;
  rbd_pkg::vec64_t  p4_r_q, p4_r_d;
  rbd_pkg::vec32_t  p1_up_q, p2_up_q, p3_up_q;
  rbd_pkg::vec32_t  p1_f_q, p2_f_q, p3_f_q, p4_f_q;
  logic signed [65:0] s_sum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p1_prod_d[i] = $signed(up_i[i]) * $signed(f_i[i]);
    end
  end

  always_comb begin
    s_sum = 66'($signed(p1_prod_q[0])) + 66'($signed(p1_prod_q[1]))
          + 66'($signed(p1_prod_q[2]));
    p2_t_d = rbd_pkg::round_q30(s_sum);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p3_ft_d[i] = $signed(p2_f_q[i]) * p2_t_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p4_r_d[i] = 64'($signed({{6{p3_up_q[i][31]}}, p3_up_q[i], 30'b0})
                    - $signed(p3_ft_q[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      p3_valid_q <= 1'b0;
      p4_valid_q <= 1'b0;
    end else if (en_i) begin
      p1_valid_q <= valid_i;
      p2_valid_q <= p1_valid_q;
      p3_valid_q <= p2_valid_q;
      p4_valid_q <= p3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_prod_q <= p1_prod_d;
      p1_up_q   <= up_i;
      p1_f_q    <= f_i;
      p2_t_q    <= p2_t_d;
      p2_up_q   <= p1_up_q;
      p2_f_q    <= p1_f_q;
      p3_ft_q   <= p3_ft_d;
      p3_up_q   <= p2_up_q;
      p3_f_q    <= p2_f_q;
      p4_r_q    <= p4_r_d;
      p4_f_q    <= p3_f_q;
    end
  end

  assign valid_o = p4_valid_q;
  assign r_o     = p4_r_q;
  assign f_o     = p4_f_q;

endmodule

### rtl/rbd_cross.sv
module rbd_cross (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  rbd_pkg::vec32_t nu_i,
  input  rbd_pkg::vec32_t f_i,
  output logic            valid_o,
  output logic [287:0]    data_o
);

  logic             x1_valid_q, x2_valid_q;
  logic [5:0][63:0] x1_prod_q, x1_prod_d;
  rbd_pkg::vec32_t  x1_nu_q, x1_f_q;
  rbd_pkg::vec32_t  x2_rt_d;
  logic [287:0]     x2_data_q;

  always_comb begin
    x1_prod_d[0] = $signed(nu_i[1]) * $signed(f_i[2]);
    x1_prod_d[1] = $signed(nu_i[2]) * $signed(f_i[1]);
    x1_prod_d[2] = $signed(nu_i[2]) * $signed(f_i[0]);
    x1_prod_d[3] = $signed(nu_i[0]) * $signed(f_i[2]);
    x1_prod_d[4] = $signed(nu_i[0]) * $signed(f_i[1]);
    x1_prod_d[5] = $signed(nu_i[1]) * $signed(f_i[0]);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x2_rt_d[i] = rbd_pkg::sat_one(rbd_pkg::round_q30(
                     66'($signed(x1_prod_q[2*i])) - 66'($signed(x1_prod_q[2*i+1]))));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_valid_q <= 1'b0;
      x2_valid_q <= 1'b0;
    end else if (en_i) begin
      x1_valid_q <= valid_i;
      x2_valid_q <= x1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_prod_q <= x1_prod_d;
      x1_nu_q   <= nu_i;
      x1_f_q    <= f_i;
      x2_data_q <= {x1_f_q, x1_nu_q, x2_rt_d};
    end
  end

  assign valid_o = x2_valid_q;
  assign data_o  = x2_data_q;

endmodule
